### rtl/pbd_pkg.sv
// Shared types and constants of the pulse beat detector.
// Used by the top level, the history RAM wiring and the serial divider.
package pbd_pkg;

    // Depth of the interbeat interval history.
    localparam int HISTORY_DEPTH = 10;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    // Field and state widths.
    localparam int MV_W      = 12;
    localparam int IVL_W     = 16;
    localparam int TIME_W    = 32;
    localparam int BPM_W     = 8;
    localparam int PERIOD_W  = 8;
    localparam int SUM_W     = IVL_W + HIST_AW;
    localparam int DIV_W     = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD     = 1'b1;

    // Detector constants.
    localparam logic [MV_W-1:0]     PT_DEFAULT      = 12'd1650;
    localparam logic [MV_W-1:0]     AMP_DEFAULT     = 12'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT  = 8'd2;
    localparam logic [TIME_W-1:0]   NOISE_MS        = 32'd400;
    localparam logic [TIME_W-1:0]   TIMEOUT_MS      = 32'd1200;
    localparam logic [IVL_W-1:0]    IBI_RESET       = 16'd750;
    localparam logic [IVL_W-1:0]    IBI_TIMEOUT     = 16'd600;
    localparam logic [DIV_W-1:0]    MS_PER_MIN      = DIV_W'(60000);
    localparam logic [BPM_W-1:0]    BPM_MAX         = 8'd255;

    // Exact floor(x / 5) for 16-bit x: (x * 0xCCCD) >> 18.
    localparam logic [IVL_W-1:0] DIV5_RECIP = 16'hCCCD;
    localparam int               DIV5_SHIFT = 18;

    // Exact floor(sum / HISTORY_DEPTH) for any sum below 2**SUM_W:
    // (sum * MEAN_RECIP) >> MEAN_SHIFT, with MEAN_RECIP rounded up.
    localparam int MEAN_SHIFT = SUM_W + HIST_AW;
    localparam logic [MEAN_SHIFT-1:0] MEAN_RECIP =
        MEAN_SHIFT'(((64'd1 << MEAN_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1)
                    / 64'(HISTORY_DEPTH));

    // Request and response of the serial divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

### rtl/pulse_beat_detector.sv
// Pulse beat detector: top level with control sequencer and state registers.
// Depends on pbd_pkg, pbd_ram (interval history) and pbd_divider.
//
// The block takes one pulse-sensor sample in millivolts per item and returns
// one result item for it: the in-beat flag, whether this sample produced a
// new rate, the averaged beats per minute, the last interbeat interval, the
// amplitude of the last completed beat and the current adaptive threshold.
// One item is processed at a time. A sample that is not a counted beat goes
// from acceptance through S_ELAP and S_DECIDE to S_DONE, which loads the
// result. A counted beat updates the interval history in a RAM (read in S_RD,
// then write back in S_UPD), forms the mean interval in S_MEAN by multiplying
// the running sum with a fixed reciprocal of the history depth, and then runs
// the one-bit-per-cycle divider for 60000 over the mean. The beat that seeds
// the history writes every entry in turn in S_SEED, in place of the read and
// write back. The history RAM needs no clearing after reset: a seeding beat
// always writes all entries before any of them is read. The result sits in
// an output register, so a new sample is accepted while an earlier result
// still waits. Configuration is written through a plain write port; the user
// must write it only while the block is idle, which the block itself does
// not enforce. Writing the default threshold also loads the live threshold.
module pulse_beat_detector (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Sample input channel.
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [pbd_pkg::MV_W-1:0]     i_sample_mv,
    // Result output channel.
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_in_beat,
    output logic                         o_beat_counted,
    output logic [pbd_pkg::BPM_W-1:0]    o_beats_per_minute,
    output logic [pbd_pkg::IVL_W-1:0]    o_beat_interval_ms,
    output logic [pbd_pkg::MV_W-1:0]     o_amplitude_mv,
    output logic [pbd_pkg::MV_W-1:0]     o_threshold_mv
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_ELAP      = 10'b00_0000_0010,
        S_DECIDE    = 10'b00_0000_0100,
        S_SEED      = 10'b00_0000_1000,
        S_RD        = 10'b00_0001_0000,
        S_UPD       = 10'b00_0010_0000,
        S_MEAN      = 10'b00_0100_0000,
        S_RATE_GO   = 10'b00_1000_0000,
        S_RATE_WAIT = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } t_state;

    // Control and detector state.
    t_state                          r_state,   n_state;
    logic [pbd_pkg::MV_W-1:0]        r_def_thr, n_def_thr;
    logic [pbd_pkg::PERIOD_W-1:0]    r_period,  n_period;
    logic [pbd_pkg::TIME_W-1:0]      r_time,    n_time;
    logic [pbd_pkg::TIME_W-1:0]      r_last,    n_last;
    logic [pbd_pkg::MV_W-1:0]        r_peak,    n_peak;
    logic [pbd_pkg::MV_W-1:0]        r_trough,  n_trough;
    logic [pbd_pkg::MV_W-1:0]        r_thr,     n_thr;
    logic [pbd_pkg::MV_W-1:0]        r_amp,     n_amp;
    logic [pbd_pkg::IVL_W-1:0]       r_interval, n_interval;
    logic [pbd_pkg::BPM_W-1:0]       r_rate,    n_rate;
    logic                            r_pulse,   n_pulse;
    logic                            r_first,   n_first;
    logic                            r_second,  n_second;
    logic                            r_counted, n_counted;
    logic [pbd_pkg::HIST_AW-1:0]     r_wptr,    n_wptr;
    logic [pbd_pkg::HIST_AW-1:0]     r_hcnt,    n_hcnt;
    logic [pbd_pkg::SUM_W-1:0]       r_sum,     n_sum;
    logic                            r_ovalid,  n_ovalid;

    // Per-item working registers.
    logic [pbd_pkg::MV_W-1:0]        r_sig;
    logic [pbd_pkg::IVL_W-3:0]       r_q5;
    logic [pbd_pkg::TIME_W-1:0]      r_elapsed;
    logic [pbd_pkg::IVL_W-1:0]       r_guard;
    logic [pbd_pkg::IVL_W-1:0]       r_mean;

    // Output payload registers.
    logic                            r_o_in_beat;
    logic                            r_o_counted;
    logic [pbd_pkg::BPM_W-1:0]       r_o_bpm;
    logic [pbd_pkg::IVL_W-1:0]       r_o_ibi;
    logic [pbd_pkg::MV_W-1:0]        r_o_amp;
    logic [pbd_pkg::MV_W-1:0]        r_o_thr;

    logic                            w_accept;
    logic                            w_load_out;
    logic [2*pbd_pkg::IVL_W-1:0]     w_prod;
    logic [pbd_pkg::SUM_W+pbd_pkg::MEAN_SHIFT-1:0] w_mean_prod;

    // Decision terms, valid in S_DECIDE.
    logic                            w_below;
    logic                            w_above;
    logic                            w_past_guard;
    logic                            w_beat;
    logic                            w_timeout;
    logic [pbd_pkg::MV_W-1:0]        w_trough_a;
    logic [pbd_pkg::MV_W-1:0]        w_peak_a;
    logic [pbd_pkg::MV_W-1:0]        w_amp_new;
    logic [pbd_pkg::MV_W-1:0]        w_thr_new;

    // History RAM and divider connections.
    logic                            w_mem_we;
    logic [pbd_pkg::HIST_AW-1:0]     w_mem_waddr;
    logic [pbd_pkg::IVL_W-1:0]       w_mem_rdata;
    pbd_pkg::t_div_req               w_div_req;
    pbd_pkg::t_div_rsp               w_div_rsp;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_load_out = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    // Guard time is 3/5 of the last interval; floor(interval / 5) by reciprocal.
    assign w_prod = r_interval * pbd_pkg::DIV5_RECIP;

    // Mean of the history: the running sum times the reciprocal of the depth.
    assign w_mean_prod = r_sum * pbd_pkg::MEAN_RECIP;

    assign w_below      = r_sig < r_thr;
    assign w_above      = r_sig > r_thr;
    assign w_past_guard = r_elapsed > {{(pbd_pkg::TIME_W-pbd_pkg::IVL_W){1'b0}}, r_guard};
    assign w_beat       = (r_elapsed > pbd_pkg::NOISE_MS) && w_above && !r_pulse
                          && w_past_guard;
    assign w_timeout    = r_elapsed > pbd_pkg::TIMEOUT_MS;

    // The trough only follows the signal once the guard time has passed.
    assign w_trough_a = (w_below && w_past_guard && (r_sig < r_trough)) ? r_sig : r_trough;
    assign w_peak_a   = (w_above && (r_sig > r_peak)) ? r_sig : r_peak;
    assign w_amp_new  = w_peak_a - w_trough_a;
    assign w_thr_new  = {1'b0, w_amp_new[pbd_pkg::MV_W-1:1]} + w_trough_a;

    always_comb begin
        n_state    = r_state;
        n_def_thr  = r_def_thr;
        n_period   = r_period;
        n_time     = r_time;
        n_last     = r_last;
        n_peak     = r_peak;
        n_trough   = r_trough;
        n_thr      = r_thr;
        n_amp      = r_amp;
        n_interval = r_interval;
        n_rate     = r_rate;
        n_pulse    = r_pulse;
        n_first    = r_first;
        n_second   = r_second;
        n_counted  = r_counted;
        n_wptr     = r_wptr;
        n_hcnt     = r_hcnt;
        n_sum      = r_sum;
        n_ovalid   = r_ovalid;

        w_mem_we    = 1'b0;
        w_mem_waddr = r_wptr;

        w_div_req.start    = 1'b0;
        w_div_req.dividend = pbd_pkg::MS_PER_MIN;
        w_div_req.divisor  = {{pbd_pkg::HIST_AW{1'b0}}, r_mean};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_time  = r_time + {{(pbd_pkg::TIME_W-pbd_pkg::PERIOD_W){1'b0}}, r_period};
                    n_state = S_ELAP;
                end
            end

            S_ELAP: begin
                n_state = S_DECIDE;
            end

            S_DECIDE: begin
                n_trough  = w_trough_a;
                n_peak    = w_peak_a;
                n_counted = 1'b0;
                n_state   = S_DONE;
                if (w_beat) begin
                    n_pulse    = 1'b1;
                    n_interval = r_elapsed[pbd_pkg::IVL_W-1:0];
                    n_last     = r_time;
                    if (r_first) begin
                        // The first beat only arms the second one.
                        n_first  = 1'b0;
                        n_second = 1'b1;
                    end else if (!w_timeout) begin
                        if (r_second) begin
                            n_second = 1'b0;
                            n_sum    = '0;
                            n_hcnt   = '0;
                            n_state  = S_SEED;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end else if (w_below && r_pulse) begin
                    // Falling crossing ends the beat; threshold to mid-amplitude.
                    n_pulse  = 1'b0;
                    n_amp    = w_amp_new;
                    n_thr    = w_thr_new;
                    n_peak   = w_thr_new;
                    n_trough = w_thr_new;
                end

                // A timeout overrides everything except the first beat. In a
                // beat sample it also skips the history update, safe since the
                // history is seeded again before its next use.
                if (w_timeout && !(w_beat && r_first)) begin
                    n_thr      = r_def_thr;
                    n_peak     = pbd_pkg::PT_DEFAULT;
                    n_trough   = pbd_pkg::PT_DEFAULT;
                    n_last     = r_time;
                    n_first    = 1'b1;
                    n_second   = 1'b0;
                    n_rate     = '0;
                    n_interval = pbd_pkg::IBI_TIMEOUT;
                    n_pulse    = 1'b0;
                    n_amp      = pbd_pkg::AMP_DEFAULT;
                    n_state    = S_DONE;
                end
            end

            S_SEED: begin
                // Fill every entry with the new interval and build the sum.
                w_mem_we    = 1'b1;
                w_mem_waddr = r_hcnt;
                n_sum       = r_sum + {{pbd_pkg::HIST_AW{1'b0}}, r_interval};
                n_hcnt      = r_hcnt + 1'b1;
                if (r_hcnt == pbd_pkg::HIST_AW'(pbd_pkg::HISTORY_DEPTH - 1)) begin
                    n_state = S_MEAN;
                end
            end

            S_RD: begin
                n_state = S_UPD;
            end

            S_UPD: begin
                // Replace the oldest interval and keep the running sum.
                w_mem_we = 1'b1;
                n_sum    = r_sum - {{pbd_pkg::HIST_AW{1'b0}}, w_mem_rdata}
                           + {{pbd_pkg::HIST_AW{1'b0}}, r_interval};
                if (r_wptr == pbd_pkg::HIST_AW'(pbd_pkg::HISTORY_DEPTH - 1)) begin
                    n_wptr = '0;
                end else begin
                    n_wptr = r_wptr + 1'b1;
                end
                n_state = S_MEAN;
            end

            S_MEAN: begin
                n_state = S_RATE_GO;
            end

            S_RATE_GO: begin
                w_div_req.start = 1'b1;
                n_state         = S_RATE_WAIT;
            end

            S_RATE_WAIT: begin
                if (w_div_rsp.done) begin
                    if (r_mean == '0) begin
                        n_rate = '0;
                    end else if (w_div_rsp.quotient > {{(pbd_pkg::DIV_W-pbd_pkg::BPM_W){1'b0}},
                                                       pbd_pkg::BPM_MAX}) begin
                        n_rate = pbd_pkg::BPM_MAX;
                    end else begin
                        n_rate = w_div_rsp.quotient[pbd_pkg::BPM_W-1:0];
                    end
                    n_counted = 1'b1;
                    n_state   = S_DONE;
                end
            end

            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output register handshake.
        if (w_load_out) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        // The user must send configuration writes only while idle; not enforced.
        if (i_cfg_we) begin
            case (i_cfg_index)
                pbd_pkg::REG_DEFAULT_THRESHOLD: begin
                    n_def_thr = i_cfg_data;
                    n_thr     = i_cfg_data;
                end
                pbd_pkg::REG_SAMPLE_PERIOD: begin
                    n_period = i_cfg_data[pbd_pkg::PERIOD_W-1:0];
                end
                default: begin
                    n_period = r_period;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_def_thr  <= pbd_pkg::PT_DEFAULT;
            r_period   <= pbd_pkg::PERIOD_DEFAULT;
            r_time     <= '0;
            r_last     <= '0;
            r_peak     <= pbd_pkg::PT_DEFAULT;
            r_trough   <= pbd_pkg::PT_DEFAULT;
            r_thr      <= pbd_pkg::PT_DEFAULT;
            r_amp      <= pbd_pkg::AMP_DEFAULT;
            r_interval <= pbd_pkg::IBI_RESET;
            r_rate     <= '0;
            r_pulse    <= 1'b0;
            r_first    <= 1'b1;
            r_second   <= 1'b0;
            r_counted  <= 1'b0;
            r_wptr     <= '0;
            r_hcnt     <= '0;
            r_sum      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_def_thr  <= n_def_thr;
            r_period   <= n_period;
            r_time     <= n_time;
            r_last     <= n_last;
            r_peak     <= n_peak;
            r_trough   <= n_trough;
            r_thr      <= n_thr;
            r_amp      <= n_amp;
            r_interval <= n_interval;
            r_rate     <= n_rate;
            r_pulse    <= n_pulse;
            r_first    <= n_first;
            r_second   <= n_second;
            r_counted  <= n_counted;
            r_wptr     <= n_wptr;
            r_hcnt     <= n_hcnt;
            r_sum      <= n_sum;
            r_ovalid   <= n_ovalid;
        end
    end

    // Per-item working values and the output payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sig <= i_sample_mv;
            r_q5  <= w_prod[2*pbd_pkg::IVL_W-1:pbd_pkg::DIV5_SHIFT];
        end
        if (r_state == S_ELAP) begin
            r_elapsed <= r_time - r_last;
            r_guard   <= {1'b0, r_q5, 1'b0} + {2'b00, r_q5};
        end
        if (r_state == S_MEAN) begin
            r_mean <= w_mean_prod[pbd_pkg::MEAN_SHIFT +: pbd_pkg::IVL_W];
        end
        if (w_load_out) begin
            r_o_in_beat <= r_pulse;
            r_o_counted <= r_counted;
            r_o_bpm     <= r_rate;
            r_o_ibi     <= r_interval;
            r_o_amp     <= r_amp;
            r_o_thr     <= r_thr;
        end
    end

    pbd_ram #(
        .WIDTH (pbd_pkg::IVL_W),
        .DEPTH (pbd_pkg::HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (r_interval),
        .i_raddr (r_wptr),
        .o_rdata (w_mem_rdata)
    );

    pbd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_valid            = r_ovalid;
    assign o_in_beat          = r_o_in_beat;
    assign o_beat_counted     = r_o_counted;
    assign o_beats_per_minute = r_o_bpm;
    assign o_beat_interval_ms = r_o_ibi;
    assign o_amplitude_mv     = r_o_amp;
    assign o_threshold_mv     = r_o_thr;

endmodule

### rtl/pbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pbd_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pbd_pkg for widths and the request and response structs.
module pbd_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pbd_pkg::t_div_req  i_req,
    output pbd_pkg::t_div_rsp  o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [pbd_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [pbd_pkg::DIV_W:0]       r_rem;
    logic [pbd_pkg::DIV_W-1:0]     r_quo;
    logic [pbd_pkg::DIV_W-1:0]     r_dvs;

    logic [pbd_pkg::DIV_W:0] w_rem_sh;
    logic [pbd_pkg::DIV_W:0] w_diff;
    logic                    w_fits;

    // Shift in the next dividend bit and try a subtraction.
    assign w_rem_sh = {r_rem[pbd_pkg::DIV_W-1:0], r_quo[pbd_pkg::DIV_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign w_fits   = w_rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= pbd_pkg::DIV_CNT_W'(pbd_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == pbd_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff : w_rem_sh;
            r_quo <= {r_quo[pbd_pkg::DIV_W-2:0], w_fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
